// ===== rtl/hpse_pkg.sv =====
// Shared types, constants and helper functions for the Halton pixel sample core.
`timescale 1ns / 1ps
package hpse_pkg;

    localparam int MAX_EXP_X  = 8;
    localparam int MAX_EXP_Y  = 5;
    localparam int TERN_DIGS  = 26;
    localparam int DIV_STEPS  = 25;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CFG_EXP_X     = 2'd0,
        CFG_EXP_Y     = 2'd1,
        CFG_INVERSE_X = 2'd2,
        CFG_INVERSE_Y = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [31:0] sample_number;
    } t_in_item;

    typedef struct packed {
        logic [47:0] seq_index;
        logic [31:0] frac_x;
        logic [31:0] frac_y;
    } t_out_item;

    typedef struct packed {
        logic [15:0] pixel_y;
        logic [7:0]  lx;
        logic [31:0] sample_number;
    } t_job;

    typedef struct packed {
        logic [3:0]  ex;
        logic [2:0]  ey;
        logic [7:0]  inv_x;
        logic [7:0]  inv_y;
        logic [8:0]  w;
        logic [7:0]  h;
        logic [15:0] stride;
    } t_cfg;

    function automatic logic [7:0] pow3(input logic [2:0] e);
        logic [7:0] p;
        case (e)
            3'd0:    p = 8'd1;
            3'd1:    p = 8'd3;
            3'd2:    p = 8'd9;
            3'd3:    p = 8'd27;
            3'd4:    p = 8'd81;
            default: p = 8'd243;
        endcase
        return p;
    endfunction

    // v < 3*2^20: quotient by 3 via reciprocal 2^24/3, exact in this range
    function automatic logic [21:0] div3(input logic [21:0] v);
        logic [44:0] p;
        logic [19:0] q;
        logic [21:0] r;
        p = {23'd0, v} * 45'd5592406;
        q = p[43:24];
        r = v - ({2'd0, q} * 22'd3);
        return {q, r[1:0]};
    endfunction

endpackage

// ===== rtl/halton_pixel_sample_enum_core.sv =====
// Top level: configuration registers, front end, job queue and sequencer.
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_data carries a pixel x, y and
//   sample number; a transfer happens when valid is high and stall is low.
//   Output channel o_out_valid / i_out_stall / o_out_data returns the Halton
//   index and the Q0.32 offsets within the pixel, one result per input, in order.
//   Configuration: i_cfg_we, i_cfg_index, i_cfg_data write exp_x, exp_y,
//   inverse_x, inverse_y; write only while the block holds no work.
//   From transfer into the queue to the output register, each item passes
//   two 25-step restoring divisions (mod stride, then div height) and has
//   26 ternary digits taken apart and folded back on the shared
//   divide-by-three step. One item is worked on at a time, so a new item is
//   taken only once the last has reached the output register; a two-entry
//   queue absorbs input bursts. Reset zeroes the configuration registers and
//   empties the queue; input is held off after reset while derived config
//   settles. A stalled receiver holds the result in the output register, and
//   the sequencer waits at its last step until it frees.
`timescale 1ns / 1ps
module halton_pixel_sample_enum_core
    import hpse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    logic [3:0]  r_exp_x;
    logic [2:0]  r_exp_y;
    logic [7:0]  r_inv_x;
    logic [7:0]  r_inv_y;
    t_cfg        r_cfg;
    t_cfg        n_cfg;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job job_in;
    t_job job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_x <= 4'd0;
            r_exp_y <= 3'd0;
            r_inv_x <= 8'd0;
            r_inv_y <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_EXP_X:     r_exp_x <= i_cfg_data[3:0];
                CFG_EXP_Y:     r_exp_y <= i_cfg_data[2:0];
                CFG_INVERSE_X: r_inv_x <= i_cfg_data;
                CFG_INVERSE_Y: r_inv_y <= i_cfg_data;
                default:       r_inv_y <= r_inv_y;
            endcase
        end
    end

    always_comb begin
        n_cfg.ex     = (r_exp_x > 4'(MAX_EXP_X)) ? 4'(MAX_EXP_X) : r_exp_x;
        n_cfg.ey     = (r_exp_y > 3'(MAX_EXP_Y)) ? 3'(MAX_EXP_Y) : r_exp_y;
        n_cfg.inv_x  = r_inv_x;
        n_cfg.inv_y  = r_inv_y;
        n_cfg.w      = 9'd1 << n_cfg.ex;
        n_cfg.h      = pow3(n_cfg.ey);
        n_cfg.stride = 16'({8'd0, n_cfg.w} * {9'd0, n_cfg.h});
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    hpse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_ex       (n_cfg.ex),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (job_in)
    );

    hpse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    hpse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );
endmodule

// ===== rtl/hpse_front.sv =====
// Front end: accepts items, reverses the binary digits of pixel x, feeds the queue.
`timescale 1ns / 1ps
module hpse_front
    import hpse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    input  logic [3:0] i_ex,
    input  logic     i_q_full,
    output logic     o_push,
    output t_job     o_job
);
    logic [7:0] rev8;
    logic       r_seen;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            rev8[7 - i] = i_in_data.pixel_x[i];
        end
    end

    assign o_in_stall = i_q_full | ~r_seen;
    assign o_push     = i_in_valid & ~o_in_stall;

    always_comb begin
        o_job.pixel_y       = i_in_data.pixel_y;
        o_job.lx            = rev8 >> (4'd8 - i_ex);
        o_job.sample_number = i_in_data.sample_number;
    end

    // hold off input after reset until r_seen is set, so derived config settles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end
endmodule

// ===== rtl/hpse_queue.sv =====
// Two-entry job queue between the front end and the sequencer.
`timescale 1ns / 1ps
module hpse_queue
    import hpse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);
    t_job       r_mem [QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== rtl/hpse_back.sv =====
// Sequencer: digit reversal, offset mod stride, radical inverses, output register.
`timescale 1ns / 1ps
module hpse_back
    import hpse_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_empty,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);
    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_LY   = 11'b000_0000_0010,
        ST_MUL1 = 11'b000_0000_0100,
        ST_MUL2 = 11'b000_0000_1000,
        ST_MUL3 = 11'b000_0001_0000,
        ST_MOD  = 11'b000_0010_0000,
        ST_QH   = 11'b000_0100_0000,
        ST_N    = 11'b000_1000_0000,
        ST_DIG  = 11'b001_0000_0000,
        ST_HOR  = 11'b010_0000_0000,
        ST_OUT  = 11'b100_0000_0000
    } t_state;

    t_state      r_state;
    logic [4:0]  r_cnt;
    logic        r_ph;
    logic [1:0]  r_r3;
    logic [39:0] r_x;
    logic [7:0]  r_lx;
    logic [7:0]  r_ly;
    logic [31:0] r_sample;
    logic [15:0] r_pa;
    logic [15:0] r_pb;
    logic [24:0] r_acc;
    logic [24:0] r_d;
    logic [15:0] r_rem;
    logic [15:0] r_dsor;
    logic [15:0] r_first;
    logic [47:0] r_n;
    logic [51:0] r_stack;
    logic [31:0] r_t;
    logic        r_ovalid;
    t_out_item   r_odata;

    logic [19:0] hi_src;
    logic [21:0] dv_in;
    logic [21:0] dv_out;
    logic [19:0] dq;
    logic [1:0]  dr;
    logic [16:0] trial;
    logic        tge;
    logic [15:0] rem_nx;
    logic [47:0] nsh;
    logic [31:0] fx;
    logic        out_free;

    assign hi_src = (r_state == ST_HOR) ? {6'd0, r_stack[1:0], r_t[31:20]} : r_x[39:20];
    assign dv_in  = r_ph ? {r_r3, r_x[19:0]} : {2'd0, hi_src};
    assign dv_out = div3(dv_in);
    assign dq     = dv_out[21:2];
    assign dr     = dv_out[1:0];

    assign trial  = {r_rem, r_d[24]};
    assign tge    = (trial >= {1'b0, r_dsor});
    assign rem_nx = tge ? 16'(trial - {1'b0, r_dsor}) : trial[15:0];

    assign nsh = r_n >> i_cfg.ex;
    always_comb begin
        for (int i = 0; i < 32; i++) begin
            fx[31 - i] = nsh[i];
        end
    end

    assign out_free    = ~r_ovalid | ~i_out_stall;
    assign o_pop       = (r_state == ST_IDLE) & ~i_q_empty;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == ST_OUT) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= 5'd0;
            r_ph     <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_lx     <= i_job.lx;
                        r_sample <= i_job.sample_number;
                        r_x      <= {24'd0, i_job.pixel_y};
                        r_ly     <= 8'd0;
                        r_cnt    <= 5'd0;
                        r_ph     <= 1'b0;
                        r_state  <= ST_LY;
                    end
                end
                ST_LY: begin
                    if (r_cnt == {2'd0, i_cfg.ey}) begin
                        r_state <= ST_MUL1;
                    end else if (!r_ph) begin
                        r_x[39:20] <= dq;
                        r_r3       <= dr;
                        r_ph       <= 1'b1;
                    end else begin
                        r_x[19:0] <= dq;
                        r_ly      <= 8'((r_ly * 8'd3) + {6'd0, dr});
                        r_ph      <= 1'b0;
                        r_cnt     <= r_cnt + 5'd1;
                    end
                end
                ST_MUL1: begin
                    r_pa    <= {8'd0, r_lx} * {8'd0, i_cfg.h};
                    r_pb    <= 16'({8'd0, r_ly} * {7'd0, i_cfg.w});
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_acc   <= {1'b0, {8'd0, r_pa} * {16'd0, i_cfg.inv_x}};
                    r_state <= ST_MUL3;
                end
                ST_MUL3: begin
                    r_d     <= r_acc + {1'b0, {8'd0, r_pb} * {16'd0, i_cfg.inv_y}};
                    r_rem   <= 16'd0;
                    r_dsor  <= i_cfg.stride;
                    r_cnt   <= 5'd0;
                    r_state <= ST_MOD;
                end
                ST_MOD, ST_QH: begin
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_cnt <= 5'd0;
                        if (r_state == ST_MOD) begin
                            r_first <= rem_nx;
                            r_d     <= {9'd0, rem_nx};
                            r_rem   <= 16'd0;
                            r_dsor  <= {8'd0, i_cfg.h};
                            r_state <= ST_QH;
                        end else begin
                            r_rem   <= rem_nx;
                            r_d     <= {r_d[23:0], tge};
                            r_state <= ST_N;
                        end
                    end else begin
                        r_rem <= rem_nx;
                        r_d   <= {r_d[23:0], tge};
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                ST_N: begin
                    r_n     <= ({16'd0, r_sample} * {32'd0, i_cfg.stride})
                               + {32'd0, r_first};
                    r_x     <= ({8'd0, r_sample} << i_cfg.ex) + {32'd0, r_d[7:0]};
                    r_ph    <= 1'b0;
                    r_cnt   <= 5'd0;
                    r_stack <= 52'd0;
                    r_state <= ST_DIG;
                end
                ST_DIG: begin
                    if (!r_ph) begin
                        r_x[39:20] <= dq;
                        r_r3       <= dr;
                        r_ph       <= 1'b1;
                    end else begin
                        r_x[19:0] <= dq;
                        r_stack   <= {r_stack[49:0], dr};
                        r_ph      <= 1'b0;
                        if (r_cnt == 5'(TERN_DIGS - 1)) begin
                            r_cnt   <= 5'd0;
                            r_t     <= 32'd0;
                            r_state <= ST_HOR;
                        end else begin
                            r_cnt   <= r_cnt + 5'd1;
                        end
                    end
                end
                ST_HOR: begin
                    if (!r_ph) begin
                        r_x     <= {dq, r_t[19:0]};
                        r_r3    <= dr;
                        r_ph    <= 1'b1;
                    end else begin
                        r_t     <= {r_x[31:20], dq};
                        r_stack <= {2'd0, r_stack[51:2]};
                        r_ph    <= 1'b0;
                        r_cnt   <= r_cnt + 5'd1;
                        if (r_cnt == 5'(TERN_DIGS - 1)) begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_odata.seq_index <= r_n;
                        r_odata.frac_x    <= fx;
                        r_odata.frac_y    <= r_t;
                        r_state           <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
